/* hw/rtl/pwl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pwl_pkg;

    localparam int DATA_W    = 32;
    localparam int CHAN_W    = 3;
    localparam int ENTRY_W   = 6;
    localparam int LEN_W     = 7;
    localparam int LEN_REGS  = 5;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = 5;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    // one classified item as it travels from the front to the back
    typedef struct packed {
        t_op                op;
        logic [CHAN_W-1:0]  chan;
        logic [ENTRY_W-1:0] entry;
        logic [DATA_W-1:0]  bp;
        logic [DATA_W-1:0]  data;
        logic [LEN_W-1:0]   len;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_SRCH,
        S_X0,
        S_X1,
        S_MUL0,
        S_MUL1,
        S_DCHK,
        S_DIV,
        S_FIN,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

/* hw/rtl/pwl_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface pwl_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [2:0]  channel;
    logic [5:0]  entry_index;
    logic [31:0] breakpoint;
    logic [31:0] mapped_point;
    logic [31:0] sample;

    modport source (output valid, op, channel, entry_index, breakpoint, mapped_point,
                    sample, input ready);
    modport sink (input valid, op, channel, entry_index, breakpoint, mapped_point,
                  sample, output ready);
endinterface

interface pwl_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] mapped_value;
    logic [2:0]  channel_tag;

    modport source (output valid, mapped_value, channel_tag, input ready);
    modport sink (input valid, mapped_value, channel_tag, output ready);
endinterface
`default_nettype wire

/* hw/rtl/pwl_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module pwl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 320
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire [WIDTH-1:0]           i_wdata,
    input  wire [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // single write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* hw/rtl/pwl_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module pwl_front
    import pwl_pkg::*;
#(
    parameter int CHANNELS = 5,
    parameter int ENTRIES  = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    pwl_in_if.sink               i_in,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [LEN_W-1:0]      i_cfg_data,
    input  wire                  i_room,
    output logic                 o_push,
    output t_cmd                 o_cmd
);
    logic [LEN_W-1:0] r_len [LEN_REGS];
    logic             keep;
    logic [LEN_W-1:0] len;

    // length registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LEN_REGS; k++) begin
                r_len[k] <= LEN_W'(1);
            end
        end else begin
            for (int k = 0; k < LEN_REGS; k++) begin
                if (i_cfg_we && i_cfg_index == CFG_IDX_W'(k) && k < CHANNELS) begin
                    r_len[k] <= i_cfg_data;
                end
            end
        end
    end

    // classify: drop bad channels and writes past the table
    always_comb begin
        len = LEN_W'(1);
        for (int k = 0; k < LEN_REGS; k++) begin
            if (i_in.channel == CHAN_W'(k)) begin
                len = r_len[k];
            end
        end
        keep = (4'(i_in.channel) < 4'(CHANNELS)) &&
               (i_in.op == OP_QUERY || 11'(i_in.entry_index) < 11'(ENTRIES));
    end

    assign i_in.ready  = i_room;
    assign o_push      = i_in.valid && i_room && keep;
    assign o_cmd.op    = t_op'(i_in.op);
    assign o_cmd.chan  = i_in.channel;
    assign o_cmd.entry = i_in.entry_index;
    assign o_cmd.bp    = i_in.breakpoint;
    assign o_cmd.data  = (i_in.op == OP_QUERY) ? i_in.sample : i_in.mapped_point;
    assign o_cmd.len   = len;
endmodule
`default_nettype wire

/* hw/rtl/pwl_cmd_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
module pwl_cmd_fifo
    import pwl_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_cmd  i_cmd,
    output logic  o_room,
    output logic  o_valid,
    output t_cmd  o_cmd,
    input  wire   i_pop
);
    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_room  = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

    // two-entry queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != 2'd2))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != 2'd0))
        else $error("pop from empty queue");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("queue count lost a push");
`endif
endmodule
`default_nettype wire

/* hw/rtl/pwl_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module pwl_back
    import pwl_pkg::*;
#(
    parameter int CHANNELS = 5,
    parameter int ENTRIES  = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    pwl_out_if.source  o_out
);
    localparam int DEPTH = CHANNELS * ENTRIES;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(ENTRIES);
    localparam int NW    = $clog2(ENTRIES + 1);

    t_state               r_state, n_state;
    logic signed [31:0]   r_x, n_x;
    logic [CHAN_W-1:0]    r_chan, n_chan;
    logic [AW-1:0]        r_base, n_base;
    logic [NW-1:0]        r_n, n_n;
    logic [NW-1:0]        r_lo, n_lo;
    logic [NW-1:0]        r_count, n_count;
    logic [IW-1:0]        r_idx, n_idx;
    logic signed [31:0]   r_x0, n_x0;
    logic signed [31:0]   r_y0, n_y0;
    logic [32:0]          r_a, n_a;
    logic [32:0]          r_b, n_b;
    logic [32:0]          r_dx, n_dx;
    logic                 r_neg, n_neg;
    logic [65:0]          r_prod, n_prod;
    logic [32:0]          r_rem, n_rem;
    logic [31:0]          r_dvd, n_dvd;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_sat, n_sat;
    logic [31:0]          r_res, n_res;
    logic                 r_out_valid, n_out_valid;
    logic [31:0]          r_out_val, n_out_val;
    logic [CHAN_W-1:0]    r_out_chan, n_out_chan;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [AW-1:0]        ram_raddr;
    logic [63:0]          ram_rdata;
    logic signed [31:0]   rd_bp;
    logic signed [31:0]   rd_val;

    logic [AW-1:0]        cmd_base;
    logic [10:0]          len_ext;
    logic [NW-1:0]        step, lo_nx, cnt_nx, clamp_i;
    logic signed [32:0]   dx, dy, ddx;
    logic [33:0]          rem2;
    logic                 ge;
    logic [33:0]          qv, y0e, sum;

    assign rd_bp  = ram_rdata[63:32];
    assign rd_val = ram_rdata[31:0];

    pwl_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({i_cmd.bp, i_cmd.data}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out.valid        = r_out_valid;
    assign o_out.mapped_value = r_out_val;
    assign o_out.channel_tag  = r_out_chan;

    // sequencer: table writes, clamp checks, search, interpolation, division, output
    always_comb begin
        n_state = r_state;   n_x = r_x;       n_chan = r_chan;   n_base = r_base;
        n_n = r_n;           n_lo = r_lo;     n_count = r_count; n_idx = r_idx;
        n_x0 = r_x0;         n_y0 = r_y0;     n_a = r_a;         n_b = r_b;
        n_dx = r_dx;         n_neg = r_neg;   n_prod = r_prod;   n_rem = r_rem;
        n_dvd = r_dvd;       n_cnt = r_cnt;   n_sat = r_sat;     n_res = r_res;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_val = r_out_val;
        n_out_chan = r_out_chan;
        o_pop = 1'b0;
        ram_we = 1'b0;
        cmd_base = AW'(i_cmd.chan * ENTRIES);
        ram_waddr = cmd_base + AW'(IW'(i_cmd.entry));
        ram_raddr = cmd_base;
        len_ext = 11'(i_cmd.len);
        step = r_count >> 1;
        lo_nx = r_lo;
        cnt_nx = step;
        clamp_i = lo_nx;
        dx = {rd_bp[31], rd_bp} - {r_x0[31], r_x0};
        dy = {rd_val[31], rd_val} - {r_y0[31], r_y0};
        ddx = {r_x[31], r_x} - {r_x0[31], r_x0};
        rem2 = {r_rem, r_dvd[31]};
        ge = (rem2 >= {1'b0, r_dx});
        qv = r_sat ? 34'h1_0000_0000 : {2'b00, r_dvd};
        y0e = {{2{r_y0[31]}}, r_y0};
        sum = r_neg ? (y0e - qv) : (y0e + qv);

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    if (i_cmd.op == OP_WRITE) begin
                        ram_we = 1'b1;
                    end else begin
                        n_x = i_cmd.data;
                        n_chan = i_cmd.chan;
                        n_base = cmd_base;
                        if (len_ext == 11'd0) begin
                            n_n = NW'(1);
                        end else if (len_ext > 11'(ENTRIES)) begin
                            n_n = NW'(ENTRIES);
                        end else begin
                            n_n = NW'(len_ext);
                        end
                        n_state = S_FIRST;
                    end
                end
            end
            S_FIRST: begin
                ram_raddr = r_base + AW'(IW'(r_n - NW'(1)));
                if (r_x <= rd_bp) begin
                    n_res = rd_val;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                ram_raddr = r_base + AW'(IW'(r_n >> 1));
                n_lo = '0;
                n_count = r_n;
                if (r_x >= rd_bp) begin
                    n_res = rd_val;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                // one halving step of the upper-bound search per cycle
                if (!(r_x < rd_bp)) begin
                    lo_nx = r_lo + step + NW'(1);
                    cnt_nx = r_count - step - NW'(1);
                end
                if (lo_nx < NW'(1)) begin
                    clamp_i = NW'(1);
                end else if (lo_nx > r_n - NW'(1)) begin
                    clamp_i = r_n - NW'(1);
                end else begin
                    clamp_i = lo_nx;
                end
                n_lo = lo_nx;
                n_count = cnt_nx;
                n_idx = IW'(clamp_i);
                if (cnt_nx == '0) begin
                    ram_raddr = r_base + AW'(IW'(clamp_i - NW'(1)));
                    n_state = S_X0;
                end else begin
                    ram_raddr = r_base + AW'(IW'(lo_nx + (cnt_nx >> 1)));
                end
            end
            S_X0: begin
                n_x0 = rd_bp;
                n_y0 = rd_val;
                ram_raddr = r_base + AW'(r_idx);
                n_state = S_X1;
            end
            S_X1: begin
                if (dx[32] || dx == '0) begin
                    n_res = r_y0;
                    n_state = S_EMIT;
                end else begin
                    n_a = dy[32] ? 33'(-dy) : 33'(dy);
                    n_b = ddx[32] ? 33'(-ddx) : 33'(ddx);
                    n_neg = dy[32] ^ ddx[32];
                    n_dx = dx;
                    n_state = S_MUL0;
                end
            end
            S_MUL0: begin
                n_prod = 66'(r_a * r_b[16:0]);
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_prod = r_prod + (66'(r_a * r_b[32:17]) << 17);
                n_state = S_DCHK;
            end
            S_DCHK: begin
                // quotient of 2^32 or more saturates anyway
                if (r_prod[65:32] >= {1'b0, r_dx}) begin
                    n_sat = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_sat = 1'b0;
                    n_rem = r_prod[64:32];
                    n_dvd = r_prod[31:0];
                    n_cnt = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = ge ? 33'(rem2 - {1'b0, r_dx}) : rem2[32:0];
                n_dvd = {r_dvd[30:0], ge};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
                    n_res = sum[31:0];
                end else if (sum[33]) begin
                    n_res = 32'h8000_0000;
                end else begin
                    n_res = 32'h7FFF_FFFF;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_val = r_res;
                    n_out_chan = r_chan;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_x <= n_x;     r_chan <= n_chan;   r_base <= n_base;   r_n <= n_n;
        r_lo <= n_lo;   r_count <= n_count; r_idx <= n_idx;     r_x0 <= n_x0;
        r_y0 <= n_y0;   r_a <= n_a;         r_b <= n_b;         r_dx <= n_dx;
        r_neg <= n_neg; r_prod <= n_prod;   r_rem <= n_rem;     r_dvd <= n_dvd;
        r_cnt <= n_cnt; r_sat <= n_sat;     r_res <= n_res;
        r_out_val <= n_out_val;
        r_out_chan <= n_out_chan;
    end

`ifndef SYNTHESIS
    a_search_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_count != '0 && r_lo <= r_n))
        else $error("search window empty or past table end");
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_dx))
        else $error("division remainder not below divisor");
    a_span_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL0) |-> (!r_dx[32] && r_dx != '0))
        else $error("interpolating over a non-positive span");
    a_emit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && (!r_out_valid || o_out.ready)) |=> r_out_valid)
        else $error("result not loaded into output register");
`endif
endmodule
`default_nettype wire

/* hw/rtl/piecewise_linear_table_map.sv */
`timescale 1ns / 1ps
`default_nettype none
// Piecewise-linear table map with one table of breakpoints and values per channel.
// Input channel i_in (valid/ready): op 0 stores one breakpoint/value pair at
// entry_index of a channel, op 1 maps sample through that channel's table.
// Output channel o_out (valid/ready): one mapped_value and channel_tag per query;
// writes and items for absent channels give no result.
// Configuration: i_cfg_we/i_cfg_index/i_cfg_data set the table length per channel.
// Items pass a two-entry queue into a sequencer that reads one table entry a cycle
// while it searches. A write is stored as the sequencer pops it. A query clamped at
// the first or last entry returns that entry's value; an interpolated one runs the
// search, one cycle per search step, then a split multiply (S_MUL0, S_MUL1) and the
// bit-serial divider. Each item is registered in the queue between input transfer
// and the sequencer.
// The front keeps accepting while the queue has room, so a stalled receiver first
// fills the output register, then the queue, and then drops i_in.ready.
// Reset clears the lengths to 1 and empties the queue and output register; table
// entries hold nothing defined until written.
module piecewise_linear_table_map
    import pwl_pkg::*;
#(
    parameter int CHANNELS = 5,
    parameter int ENTRIES  = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    pwl_in_if.sink               i_in,
    pwl_out_if.source            o_out,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [LEN_W-1:0]      i_cfg_data
);
    logic room, push, q_valid, pop;
    t_cmd push_cmd, q_cmd;

    pwl_front #(.CHANNELS(CHANNELS), .ENTRIES(ENTRIES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_room      (room),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    pwl_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_room  (room),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    pwl_back #(.CHANNELS(CHANNELS), .ENTRIES(ENTRIES)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );
endmodule
`default_nettype wire
